### design/csh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_pkg
// Shared widths, codes and types of the circular sample history buffer.
// ----------------------------------------------------------------------------
package csh_pkg;

	// default sizes
	localparam int SLOTS_DEF     = 32;
	localparam int ELEM_BITS_DEF = 32;

	// fixed field widths
	localparam int CAP_W  = 6;
	localparam int ACT_W  = 2;
	localparam int VAL_W  = 32;
	localparam int LIM_W  = 6;
	localparam int STAT_W = 2;

	// capacity after reset, before clamping to the ring size
	localparam int CAP_RESET = 31;

	// action codes
	localparam logic [ACT_W-1:0] ACT_PUSH        = 2'd0;
	localparam logic [ACT_W-1:0] ACT_READ_OLDEST = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ_NEXT   = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_ELEM  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd2;

	// control side of the output stage
	typedef struct packed {
		logic              valid;
		logic [STAT_W-1:0] status;
		logic              last;
	} out_meta_t;

endpackage

### design/csh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_ram
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module csh_ram #(
	parameter int DEPTH = csh_pkg::SLOTS_DEF,
	parameter int WIDTH = csh_pkg::ELEM_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write and read; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

### design/csh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_ctrl
// Ring indices, segment computation and the read sequencer.
// ----------------------------------------------------------------------------
module csh_ctrl #(
	parameter int SLOTS = csh_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [csh_pkg::ACT_W-1:0]   action,
	input  logic [csh_pkg::LIM_W-1:0]   max_elems,
	input  logic                        cfg_we,
	input  logic [csh_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic                        out_stall,
	output logic                        ram_we,
	output logic [$clog2(SLOTS)-1:0]    ram_waddr,
	output logic                        ram_re,
	output logic [$clog2(SLOTS)-1:0]    ram_raddr,
	output csh_pkg::out_meta_t          out_meta
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CMP_W = (CNT_W > csh_pkg::LIM_W) ? CNT_W : csh_pkg::LIM_W;
	localparam int CAP_RST_I = (csh_pkg::CAP_RESET > SLOTS - 1) ? SLOTS - 1
		: csh_pkg::CAP_RESET;
	localparam logic [csh_pkg::CAP_W-1:0] CAP_MAX = csh_pkg::CAP_W'(SLOTS - 1);
	localparam logic [csh_pkg::CAP_W-1:0] CAP_MIN = csh_pkg::CAP_W'(2);
	localparam logic [csh_pkg::CAP_W-1:0] CAP_RST = csh_pkg::CAP_W'(CAP_RST_I);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_STAT = 3'b100
	} state_t;

	state_t                      state_q;
	logic [csh_pkg::CAP_W-1:0]   cap_q;
	logic [CNT_W-1:0]            wr_q;
	logic [CNT_W-1:0]            rd_q;
	logic                        wrap_q;
	logic [IDX_W-1:0]            addr_q;
	logic [CNT_W-1:0]            remain_q;
	logic [csh_pkg::STAT_W-1:0]  stat_q;
	csh_pkg::out_meta_t          meta_s1;

	logic [csh_pkg::CAP_W-1:0]   cap_new;
	logic [CNT_W-1:0]            ring_n;
	logic [CNT_W-1:0]            wr_inc;
	logic [CNT_W-1:0]            seg_start;
	logic [CNT_W-1:0]            seg_len;
	logic [csh_pkg::STAT_W-1:0]  seg_stat;
	logic [CNT_W-1:0]            use_len;
	logic [CNT_W-1:0]            end_pos;
	logic [CNT_W-1:0]            rd_next;
	logic                        accept;
	logic                        adv;
	logic                        issue_rd;
	logic                        issue_any;

	// capacity clamp to 2 .. SLOTS-1
	always_comb begin
		if (cfg_wdata > CAP_MAX) begin
			cap_new = CAP_MAX;
		end else if (cfg_wdata < CAP_MIN) begin
			cap_new = CAP_MIN;
		end else begin
			cap_new = cfg_wdata;
		end
	end

	assign ring_n = CNT_W'(cap_q) + CNT_W'(1);
	assign wr_inc = wr_q + CNT_W'(1);

	// segment start, length and status for a read
	always_comb begin
		seg_start = '0;
		seg_len   = '0;
		seg_stat  = csh_pkg::STAT_ELEM;
		case (action)
			csh_pkg::ACT_READ_OLDEST: begin
				if (wrap_q && (wr_inc < ring_n)) begin
					seg_start = wr_inc;
					seg_len   = ring_n - wr_inc;
				end else begin
					seg_len = wr_q;
				end
				if (seg_len == '0) begin
					seg_stat = csh_pkg::STAT_EMPTY;
				end
			end
			csh_pkg::ACT_READ_NEXT: begin
				seg_start = rd_q;
				if (rd_q == wr_q) begin
					seg_stat = csh_pkg::STAT_DONE;
				end else if (rd_q > wr_q) begin
					seg_len = ring_n - rd_q;
				end else begin
					seg_len = wr_q - rd_q;
				end
			end
			default: begin
				seg_start = '0;
			end
		endcase
	end

	// optional limit, then the read position past the segment
	always_comb begin
		if ((max_elems != '0) && (CMP_W'(max_elems) < CMP_W'(seg_len))) begin
			use_len = CNT_W'(max_elems);
		end else begin
			use_len = seg_len;
		end
		end_pos = seg_start + use_len;
		rd_next = (end_pos >= ring_n) ? '0 : end_pos;
	end

	// handshake; the store is only written in idle and only read in run,
	// so a write and a read of the same entry never overlap
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign adv       = !meta_s1.valid || !out_stall;
	assign issue_rd  = (state_q == ST_RUN) && adv;
	assign issue_any = ((state_q == ST_RUN) || (state_q == ST_STAT)) && adv;

	// indices, capacity and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cap_q    <= CAP_RST;
			wr_q     <= '0;
			rd_q     <= '0;
			wrap_q   <= 1'b0;
			addr_q   <= '0;
			remain_q <= '0;
			stat_q   <= csh_pkg::STAT_ELEM;
		end else if (cfg_we) begin
			cap_q  <= cap_new;
			wr_q   <= '0;
			rd_q   <= '0;
			wrap_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (action)
							csh_pkg::ACT_PUSH: begin
								if (wr_inc >= ring_n) begin
									wr_q   <= '0;
									wrap_q <= 1'b1;
								end else begin
									wr_q <= wr_inc;
								end
							end
							csh_pkg::ACT_READ_OLDEST, csh_pkg::ACT_READ_NEXT: begin
								rd_q <= rd_next;
								if (seg_stat != csh_pkg::STAT_ELEM) begin
									stat_q  <= seg_stat;
									state_q <= ST_STAT;
								end else begin
									addr_q   <= seg_start[IDX_W-1:0];
									remain_q <= use_len;
									state_q  <= ST_RUN;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RUN: begin
					if (adv) begin
						addr_q   <= addr_q + IDX_W'(1);
						remain_q <= remain_q - CNT_W'(1);
						if (remain_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_STAT: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output stage control, aligned with the store's read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (adv) begin
			meta_s1.valid  <= issue_any;
			meta_s1.status <= (state_q == ST_RUN) ? csh_pkg::STAT_ELEM : stat_q;
			meta_s1.last   <= (state_q == ST_RUN) ? (remain_q == CNT_W'(1)) : 1'b1;
		end
	end

	assign ram_we    = accept && (action == csh_pkg::ACT_PUSH) && !cfg_we;
	assign ram_waddr = wr_q[IDX_W-1:0];
	assign ram_re    = issue_rd;
	assign ram_raddr = addr_q;
	assign out_meta  = meta_s1;

endmodule

### design/circular_sample_history_buffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_sample_history_buffer_unit
// Overwriting history ring of sample words with segment reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one word per accept: a push
//   stores element_value, a read-from-oldest or read-next emits one
//   contiguous segment of the ring, optionally cut to max_elems elements.
//   Output channel (out_valid / out_stall) gives one element per word, the
//   final word of a read marked by last_of_run; an empty or finished read
//   gives a single status word.
//   A push is taken only while idle. A read holds the input stalled until
//   its last word (or its status word) is issued; the read is registered
//   first in the sequencer state and then in the sample store's read data,
//   and then one word per cycle follows from the store's single read port while out_stall is low.
//   When out_stall is high the current word holds and the read sequencer
//   pauses; a push may still be taken while a final word waits.
//   Reset clears the indices, the wrapped flag and the output valid, and sets
//   the capacity to 31 (clamped to SLOTS-1). The store itself is not cleared.
//   cfg_we writes the capacity (clamped to 2..SLOTS-1) and empties the ring.
// ----------------------------------------------------------------------------
module circular_sample_history_buffer_unit #(
	parameter int SLOTS     = csh_pkg::SLOTS_DEF,
	parameter int ELEM_BITS = csh_pkg::ELEM_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [csh_pkg::ACT_W-1:0]   action,
	input  logic [csh_pkg::VAL_W-1:0]   element_value,
	input  logic [csh_pkg::LIM_W-1:0]   max_elems,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [csh_pkg::VAL_W-1:0]   element_value_res,
	output logic [csh_pkg::STAT_W-1:0]  status,
	output logic                        last_of_run,
	input  logic                        cfg_we,
	input  logic [csh_pkg::CAP_W-1:0]   cfg_wdata
);

	localparam int IDX_W = $clog2(SLOTS);

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic                  ram_re;
	logic [IDX_W-1:0]      ram_raddr;
	logic [ELEM_BITS-1:0]  ram_rdata;
	logic [63:0]           wide_in;
	logic [63:0]           wide_out;
	csh_pkg::out_meta_t    out_meta;

	// sample words are masked to ELEM_BITS on the way in
	assign wide_in  = {32'd0, element_value};
	assign wide_out = 64'(ram_rdata);

	csh_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.max_elems (max_elems),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_stall (out_stall),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.out_meta  (out_meta)
	);

	csh_ram #(
		.DEPTH(SLOTS),
		.WIDTH(ELEM_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wide_in[ELEM_BITS-1:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// status words carry a zero element
	assign out_valid         = out_meta.valid;
	assign status            = out_meta.status;
	assign last_of_run       = out_meta.last;
	assign element_value_res = (out_meta.status == csh_pkg::STAT_ELEM) ? wide_out[31:0]
		: '0;

endmodule

### design/csh_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_chk
// Port-level checks of the history buffer, bound to the top level.
// ----------------------------------------------------------------------------
module csh_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [csh_pkg::ACT_W-1:0]   action,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [csh_pkg::VAL_W-1:0]   element_value_res,
	input logic [csh_pkg::STAT_W-1:0]  status,
	input logic                        last_of_run,
	input logic                        cfg_we
);

	// a stalled word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// every read produces at least one word, so the input stalls after it
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !cfg_we &&
		(action == csh_pkg::ACT_READ_OLDEST || action == csh_pkg::ACT_READ_NEXT)
		|=> in_stall)
		else $error("read accepted without entering the read sequence");

	// status words end their read
	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != csh_pkg::STAT_ELEM |-> last_of_run)
		else $error("status word not marked last");

	// status words carry a zero element
	a_stat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != csh_pkg::STAT_ELEM |-> element_value_res == '0)
		else $error("status word with nonzero element");

endmodule

bind circular_sample_history_buffer_unit csh_chk u_chk (.*);
